// ===== rtl/tpss_pkg.sv =====
// ----------------------------------------------------------------------------
// tpss_pkg: shared types and arithmetic for the triangle slice segment core
// Holds the widths, the register indexes, the word formats that travel
// between the front and back parts, and the plane distance arithmetic.
// ----------------------------------------------------------------------------
package tpss_pkg;

  // Widths of the arithmetic.
  localparam int CW = 32;           // coordinate, Q16.16
  localparam int DW = 36;           // signed plane distance, Q16.16
  localparam int AW = 35;           // distance magnitude
  localparam int SW = 36;           // sum of two distance magnitudes
  localparam int PW = 64;           // one coordinate product
  localparam int NW = CW + AW;      // dividend of one crossing
  localparam int QW = CW;           // quotient of one crossing
  localparam int DIV_STEPS = QW;    // one quotient bit per stage

  // Tolerance of 1e-3 in Q16.16 and its double.
  localparam logic signed [DW-1:0] KEEP_MIN = -36'sd66;
  localparam logic [AW-1:0] NEAR_LIM = 35'd132;

  // Configuration register indexes.
  localparam logic [2:0] REG_CUT_NX  = 3'd0;
  localparam logic [2:0] REG_CUT_NY  = 3'd1;
  localparam logic [2:0] REG_CUT_NZ  = 3'd2;
  localparam logic [2:0] REG_CUT_OFF = 3'd3;
  localparam logic [2:0] REG_KEEP_NX = 3'd4;
  localparam logic [2:0] REG_KEEP_NY = 3'd5;
  localparam logic [2:0] REG_KEEP_NZ = 3'd6;
  localparam logic [2:0] REG_KEEP_OFF = 3'd7;

  // Element 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][PW-1:0] prod_t;

  typedef struct packed {
    vec_t          n;
    logic [CW-1:0] off;
  } plane_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_PAIR,
    MODE_VERT
  } mode_t;

  // One edge crossing: u + sign(w-u) * floor(|w-u| * a / s).
  typedef struct packed {
    vec_t          u;
    vec_t          w;
    logic [AW-1:0] a;
    logic [SW-1:0] s;
  } cross_t;

  // Work word from the front part to the back part.
  typedef struct packed {
    mode_t  mode;
    cross_t x;
    cross_t y;
  } work_t;

  // Finished segment.
  typedef struct packed {
    vec_t st;
    vec_t fin;
  } seg_t;

  // Exact products of a Q2.30 normal with a Q16.16 point.
  function automatic prod_t prod3(vec_t n, vec_t v);
    prod_t r;
    logic signed [PW-1:0] en;
    logic signed [PW-1:0] ev;
    for (int i = 0; i < 3; i++) begin
      en = {{(PW-CW){n[i][CW-1]}}, n[i]};
      ev = {{(PW-CW){v[i][CW-1]}}, v[i]};
      r[i] = en * ev;
    end
    return r;
  endfunction

  // Sum of the products, floored to Q16.16, less the plane offset.
  function automatic logic signed [DW-1:0] plane_dist(prod_t p, logic [CW-1:0] off);
    logic signed [PW+1:0] acc;
    logic signed [DW-1:0] sh;
    acc = $signed({{2{p[0][PW-1]}}, p[0]}) + $signed({{2{p[1][PW-1]}}, p[1]})
        + $signed({{2{p[2][PW-1]}}, p[2]});
    sh = acc[PW+1 -: DW];
    return sh - $signed({{(DW-CW){off[CW-1]}}, off});
  endfunction

endpackage

// ===== rtl/triangle_plane_slice_segment_core.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_slice_segment_core: triangle against plane slicer
// Cuts each triangle with a configured plane and returns at most one
// segment per triangle, kept only on the chosen side of a second plane.
//
//   Channel   Direction  Handshake         Word
//   input     in         push / full       a_*, b_*, c_* vertices
//   result    out        pop / empty       start_*, finish_* segment ends
//   config    in         cfg_write         cfg_index, cfg_data
//
// One triangle is taken each cycle while full is low. The delay from a triangle
// to its segment is set mostly by the 32 stage divider lanes.
// Reset clears the plane registers, the valid bits and both queues.
// A full result queue stalls the back part, which in turn fills the middle
// queue and raises full; the front part keeps moving while the queue has room.
// ----------------------------------------------------------------------------
module triangle_plane_slice_segment_core
  import tpss_pkg::*;
#(
  parameter int MID_DEPTH_LOG2 = 2,
  parameter int OUT_DEPTH_LOG2 = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [31:0]   a_x,
  input  logic [31:0]   a_y,
  input  logic [31:0]   a_z,
  input  logic [31:0]   b_x,
  input  logic [31:0]   b_y,
  input  logic [31:0]   b_z,
  input  logic [31:0]   c_x,
  input  logic [31:0]   c_y,
  input  logic [31:0]   c_z,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   start_x,
  output logic [31:0]   start_y,
  output logic [31:0]   start_z,
  output logic [31:0]   finish_x,
  output logic [31:0]   finish_y,
  output logic [31:0]   finish_z,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  plane_t     cut;
  plane_t     keep;
  vec_t [2:0] in_vtx;
  logic       mid_push, mid_full, mid_pop, mid_empty;
  work_t      mid_wdata, mid_rdata;
  logic       out_push, out_full;
  seg_t       out_wdata, out_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cut  <= '0;
      keep <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CUT_NX:   cut.n[0]  <= cfg_data;
        REG_CUT_NY:   cut.n[1]  <= cfg_data;
        REG_CUT_NZ:   cut.n[2]  <= cfg_data;
        REG_CUT_OFF:  cut.off   <= cfg_data;
        REG_KEEP_NX:  keep.n[0] <= cfg_data;
        REG_KEEP_NY:  keep.n[1] <= cfg_data;
        REG_KEEP_NZ:  keep.n[2] <= cfg_data;
        REG_KEEP_OFF: keep.off  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word as three vertices.
  assign in_vtx[0][0] = a_x;
  assign in_vtx[0][1] = a_y;
  assign in_vtx[0][2] = a_z;
  assign in_vtx[1][0] = b_x;
  assign in_vtx[1][1] = b_y;
  assign in_vtx[1][2] = b_z;
  assign in_vtx[2][0] = c_x;
  assign in_vtx[2][1] = c_y;
  assign in_vtx[2][2] = c_z;

  tpss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_push  (push),
    .in_vtx   (in_vtx),
    .in_full  (full),
    .cut      (cut),
    .mid_push (mid_push),
    .mid_word (mid_wdata),
    .mid_full (mid_full)
  );

  tpss_fifo #(
    .WIDTH      ($bits(work_t)),
    .DEPTH_LOG2 (MID_DEPTH_LOG2)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  tpss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_word  (mid_rdata),
    .mid_pop   (mid_pop),
    .keep      (keep),
    .out_push  (out_push),
    .out_word  (out_wdata),
    .out_full  (out_full)
  );

  tpss_fifo #(
    .WIDTH      ($bits(seg_t)),
    .DEPTH_LOG2 (OUT_DEPTH_LOG2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  // Result word.
  assign start_x  = out_rdata.st[0];
  assign start_y  = out_rdata.st[1];
  assign start_z  = out_rdata.st[2];
  assign finish_x = out_rdata.fin[0];
  assign finish_y = out_rdata.fin[1];
  assign finish_z = out_rdata.fin[2];

  // A word held back by a full middle queue stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
                   mid_push && mid_full |=> mid_push && $stable(mid_wdata))
    else $error("waiting word changed at the middle queue");

  // A segment held back by a full result queue stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
                   out_push && out_full |=> out_push && $stable(out_wdata))
    else $error("waiting segment changed at the result queue");

  // Nothing waits on the result side straight after reset.
  assert property (@(posedge clk) $fell(rst) |-> empty)
    else $error("result queue not empty after reset");

endmodule

// ===== rtl/tpss_fifo.sv =====
// ----------------------------------------------------------------------------
// tpss_fifo: small register queue
// Holds words between two parts that stall independently.
// ----------------------------------------------------------------------------
module tpss_fifo #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_LOG2 = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr;
  logic [DEPTH_LOG2-1:0] rd_ptr;
  logic [DEPTH_LOG2:0]   count;
  logic                  wr_en;
  logic                  rd_en;

  // A word moves only when there is room or something to take.
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign full  = (count == (DEPTH_LOG2+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tpss_front.sv =====
// ----------------------------------------------------------------------------
// tpss_front: distance and classification part
// Computes the three cutting plane distances of a triangle over three stages
// and picks the edges to interpolate, or drops the triangle.
// ----------------------------------------------------------------------------
module tpss_front
  import tpss_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_push,
  input  vec_t [2:0]     in_vtx,
  output logic           in_full,
  input  plane_t         cut,
  output logic           mid_push,
  output work_t          mid_word,
  input  logic           mid_full
);

  logic                         val1, val2, val3;
  vec_t [2:0]                   vtx1, vtx2, vtx3;
  prod_t [2:0]                  pr2;
  logic signed [2:0][DW-1:0]    d3;
  logic                         adv;

  logic [2:0]                   pos, ng, nz, near;
  logic [2:0][AW-1:0]           dm;
  logic                         same01, same12, same20;
  logic [DW-1:0]                neg_d;

  // Crossing of edge u->w weighted by the two distance magnitudes.
  function automatic cross_t cross_of(vec_t u, vec_t w, logic [AW-1:0] au,
                                      logic [AW-1:0] aw);
    cross_t c;
    c.u = u;
    c.w = w;
    c.a = au;
    c.s = {1'b0, au} + {1'b0, aw};
    return c;
  endfunction

  // A vertex as a degenerate crossing: a zero weight returns u itself.
  function automatic cross_t vert_of(vec_t v);
    cross_t c;
    c.u = v;
    c.w = v;
    c.a = '0;
    c.s = SW'(1);
    return c;
  endfunction

  // The pipeline moves unless a word waits on a full queue.
  assign mid_push = val3 && (mid_word.mode != MODE_NONE);
  assign adv      = !mid_push || !mid_full;
  assign in_full  = !adv;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      val1 <= 1'b0;
      val2 <= 1'b0;
      val3 <= 1'b0;
    end else if (adv) begin
      val1 <= in_push;
      val2 <= val1;
      val3 <= val2;
    end
  end

  // Products, then distances.
  always_ff @(posedge clk) begin
    if (adv) begin
      vtx1 <= in_vtx;
      vtx2 <= vtx1;
      vtx3 <= vtx2;
      for (int i = 0; i < 3; i++) begin
        pr2[i] <= prod3(cut.n, vtx1[i]);
        d3[i]  <= plane_dist(pr2[i], cut.off);
      end
    end
  end

  // Signs and magnitudes of the distances.
  always_comb begin
    neg_d = '0;
    for (int i = 0; i < 3; i++) begin
      ng[i]   = d3[i][DW-1];
      pos[i]  = !d3[i][DW-1] && (d3[i] != '0);
      nz[i]   = pos[i] || ng[i];
      neg_d   = -d3[i];
      dm[i]   = ng[i] ? neg_d[AW-1:0] : d3[i][AW-1:0];
      near[i] = (dm[i] < NEAR_LIM);
    end
    same01 = nz[0] && nz[1] && (ng[0] == ng[1]);
    same12 = nz[1] && nz[2] && (ng[1] == ng[2]);
    same20 = nz[2] && nz[0] && (ng[2] == ng[0]);
  end

  // Classification: one vertex alone on its side, else a vertex near the plane.
  always_comb begin
    mid_word      = '0;
    mid_word.mode = MODE_NONE;
    if ((&nz) && !(same01 && same12)) begin
      mid_word.mode = MODE_PAIR;
      if (same01) begin
        mid_word.x = cross_of(vtx3[1], vtx3[2], dm[1], dm[2]);
        mid_word.y = cross_of(vtx3[2], vtx3[0], dm[2], dm[0]);
      end else if (same12) begin
        mid_word.x = cross_of(vtx3[0], vtx3[1], dm[0], dm[1]);
        mid_word.y = cross_of(vtx3[2], vtx3[0], dm[2], dm[0]);
      end else begin
        mid_word.x = cross_of(vtx3[0], vtx3[1], dm[0], dm[1]);
        mid_word.y = cross_of(vtx3[1], vtx3[2], dm[1], dm[2]);
      end
    end else if (near[0] && !same12) begin
      if (nz[1] || nz[2]) begin
        mid_word.mode = MODE_VERT;
        mid_word.x    = vert_of(vtx3[0]);
        mid_word.y    = cross_of(vtx3[1], vtx3[2], dm[1], dm[2]);
      end
    end else if (near[1] && !same20) begin
      if (nz[2] || nz[0]) begin
        mid_word.mode = MODE_VERT;
        mid_word.x    = vert_of(vtx3[1]);
        mid_word.y    = cross_of(vtx3[2], vtx3[0], dm[2], dm[0]);
      end
    end else if (near[2] && !same01) begin
      if (nz[0] || nz[1]) begin
        mid_word.mode = MODE_VERT;
        mid_word.x    = vert_of(vtx3[2]);
        mid_word.y    = cross_of(vtx3[0], vtx3[1], dm[0], dm[1]);
      end
    end
  end

endmodule

// ===== rtl/tpss_div.sv =====
// ----------------------------------------------------------------------------
// tpss_div: pipelined restoring divider
// Produces one quotient bit per stage; the quotient is known to fit QW bits.
// ----------------------------------------------------------------------------
module tpss_div
  import tpss_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [SW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [SW-1:0] rem   [DIV_STEPS];
  logic [CW-1:0] low   [DIV_STEPS];
  logic [QW-1:0] q_r   [DIV_STEPS];
  logic [SW-1:0] den_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [SW-1:0] rem_in;
    logic [SW-1:0] den_in;
    logic [CW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          ge;

    // The upper dividend bits start below the divisor.
    if (k == 0) begin : g_first
      assign rem_in = SW'(num[NW-1:CW]);
      assign low_in = num[CW-1:0];
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign low_in = low[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
    end

    // Shift in the next dividend bit and subtract where it fits.
    assign trial = {rem_in, low_in[CW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? diff[SW-1:0] : trial[SW-1:0];
        low[k]   <= low_in << 1;
        q_r[k]   <= {q_in[QW-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = q_r[DIV_STEPS-1];

endmodule

// ===== rtl/tpss_back.sv =====
// ----------------------------------------------------------------------------
// tpss_back: interpolation and half-space filter part
// Interpolates the two segment ends through six divider lanes, then
// measures both ends against the keep plane and passes the segment on.
// ----------------------------------------------------------------------------
module tpss_back
  import tpss_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   mid_empty,
  input  work_t  mid_word,
  output logic   mid_pop,
  input  plane_t keep,
  output logic   out_push,
  output seg_t   out_word,
  input  logic   out_full
);

  // Sideband that travels beside the dividers.
  typedef struct packed {
    mode_t                mode;
    logic [5:0][CW-1:0]   u;
    logic [5:0]           neg;
  } side_t;

  logic                       adv;
  logic                       val0, val1, val2, val3, val4;
  work_t                      w0;
  logic [5:0][CW-1:0]         dm1, u1;
  logic [5:0]                 neg1;
  logic [1:0][AW-1:0]         a1;
  logic [1:0][SW-1:0]         s1;
  mode_t                      mode1;
  logic [5:0][NW-1:0]         num2;
  logic [1:0][SW-1:0]         den2;
  side_t                      side2;
  side_t                      sb  [DIV_STEPS];
  logic                       sbv [DIV_STEPS];
  logic [5:0][QW-1:0]         quo;
  vec_t [1:0]                 p3, p4;
  mode_t                      mode3, mode4;
  prod_t [1:0]                kp4;
  logic signed [DW-1:0]       kx, ky;
  logic                       emit;

  logic [5:0][CW-1:0]         lane_u, lane_w, lane_m;
  logic [5:0][CW:0]           lane_d;
  logic [5:0]                 lane_neg;
  logic [CW:0]                ndiff;

  // The pipeline moves unless a segment waits on a full queue.
  assign adv     = !out_push || !out_full;
  assign mid_pop = adv && !mid_empty;

  // Valid bits along the stages and the divider line.
  always_ff @(posedge clk) begin
    if (rst) begin
      val0 <= 1'b0;
      val1 <= 1'b0;
      val2 <= 1'b0;
      val3 <= 1'b0;
      val4 <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        sbv[k] <= 1'b0;
      end
    end else if (adv) begin
      val0   <= !mid_empty;
      val1   <= val0;
      val2   <= val1;
      sbv[0] <= val2;
      for (int k = 1; k < DIV_STEPS; k++) begin
        sbv[k] <= sbv[k-1];
      end
      val3 <= sbv[DIV_STEPS-1];
      val4 <= val3;
    end
  end

  // Lanes 0 to 2 are the start end, lanes 3 to 5 the finish end.
  // Each lane also gets the sign and magnitude of its edge difference.
  always_comb begin
    ndiff = '0;
    for (int i = 0; i < 3; i++) begin
      lane_u[i]   = w0.x.u[i];
      lane_w[i]   = w0.x.w[i];
      lane_u[i+3] = w0.y.u[i];
      lane_w[i+3] = w0.y.w[i];
    end
    for (int k = 0; k < 6; k++) begin
      lane_d[k]   = {lane_w[k][CW-1], lane_w[k]} - {lane_u[k][CW-1], lane_u[k]};
      lane_neg[k] = lane_d[k][CW];
      ndiff       = -lane_d[k];
      lane_m[k]   = lane_neg[k] ? ndiff[CW-1:0] : lane_d[k][CW-1:0];
    end
  end

  // Word capture, edge differences and dividends.
  always_ff @(posedge clk) begin
    if (adv) begin
      w0 <= mid_word;
      for (int k = 0; k < 6; k++) begin
        neg1[k] <= lane_neg[k];
        dm1[k]  <= lane_m[k];
        u1[k]   <= lane_u[k];
      end
      a1[0] <= w0.x.a;
      a1[1] <= w0.y.a;
      s1[0] <= w0.x.s;
      s1[1] <= w0.y.s;
      mode1 <= w0.mode;
      for (int k = 0; k < 6; k++) begin
        num2[k] <= NW'(dm1[k]) * NW'(a1[k/3]);
      end
      den2       <= s1;
      side2.mode <= mode1;
      side2.u    <= u1;
      side2.neg  <= neg1;
    end
  end

  // Sideband line, aligned stage for stage with the dividers.
  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= side2;
      for (int k = 1; k < DIV_STEPS; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_lane
    tpss_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num2[k]),
      .den (den2[k/3]),
      .quo (quo[k])
    );
  end

  // Crossing points, then keep plane products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        p3[k/3][k%3] <= sb[DIV_STEPS-1].neg[k] ? sb[DIV_STEPS-1].u[k] - quo[k]
                                               : sb[DIV_STEPS-1].u[k] + quo[k];
      end
      mode3 <= sb[DIV_STEPS-1].mode;
      p4    <= p3;
      mode4 <= mode3;
      for (int i = 0; i < 2; i++) begin
        kp4[i] <= prod3(keep.n, p3[i]);
      end
    end
  end

  // Half-space filter.
  always_comb begin
    kx   = plane_dist(kp4[0], keep.off);
    ky   = plane_dist(kp4[1], keep.off);
    emit = (mode4 == MODE_PAIR) ? ((kx >= KEEP_MIN) && (ky >= KEEP_MIN)) : (ky > 0);
  end

  assign out_push     = val4 && emit;
  assign out_word.st  = p4[0];
  assign out_word.fin = p4[1];

endmodule

// ===== tb/sv/tb_triangle_plane_slice_segment_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_plane_slice_segment_core: self-checking bench for the slicer
// Streams triangles through the core under a series of plane settings. A
// directed table covers each crossing pattern, near-plane vertices and the
// cases that give no segment. Random triangles follow, many of them built
// around the planes. Every unpinned triangle is predicted here in exact
// arithmetic, and each segment word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_triangle_plane_slice_segment_core;
  import tpss_pkg::*;

  localparam int  ONE = 65536;             // 1.0 in Q16.16
  localparam logic [31:0] UNIT = 32'h4000_0000;  // 1.0 in Q2.30
  localparam int  LIMIT = 600000;
  localparam int  DRAIN = 60;
  localparam int  PHASES = 12;
  localparam int  PER_PHASE = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  vec_t va = '0, vb = '0, vc = '0;
  logic [31:0] start_x, start_y, start_z, finish_x, finish_y, finish_z;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = REG_CUT_NX;
  logic [31:0] cfg_data = '0;

  triangle_plane_slice_segment_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .a_x(va[0]), .a_y(va[1]), .a_z(va[2]),
    .b_x(vb[0]), .b_y(vb[1]), .b_z(vb[2]),
    .c_x(vc[0]), .c_y(vc[1]), .c_z(vc[2]),
    .empty(empty), .pop(pop),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .finish_x(finish_x), .finish_y(finish_y), .finish_z(finish_z),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the planes, and the segments still owed by the core.
  plane_t cut_plane = '0;
  plane_t keep_plane = '0;
  seg_t   pending_segs[$];
  int     mismatches = 0;
  int     cycles = 0;
  int     triangles = 0;
  int     segments = 0;
  int     settings = 0;
  bit     send_burst = 0;
  bit     take_burst = 0;

  typedef struct {
    vec_t a, b, c;
    bit   pinned;      // the row is known to give no segment
  } tri_row_t;

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** triangle_plane_slice_segment_core: FAILED **");
      $finish;
    end
  end

  // Signed distance of a point to a plane, Q16.16, floored.
  function automatic logic signed [67:0] plane_gap(plane_t pl, vec_t v);
    logic signed [67:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) acc += $signed(pl.n[i]) * $signed(v[i]);
    return (acc >>> 30) - $signed(pl.off);
  endfunction

  // Point where the plane crosses edge u->w.
  function automatic vec_t edge_point(vec_t u, vec_t w, logic signed [67:0] du,
                                      logic signed [67:0] dw);
    vec_t p;
    logic [67:0] am, sm;
    logic signed [33:0] diff;
    logic [33:0] dm;
    logic [103:0] prodv, q;
    am = du < 0 ? -du : du;
    sm = am + (dw < 0 ? -dw : dw);
    for (int i = 0; i < 3; i++) begin
      diff = $signed({w[i][31], w[i]}) - $signed({u[i][31], u[i]});
      dm = diff < 0 ? -diff : diff;
      prodv = dm * am;
      q = (sm == 0) ? '0 : prodv / sm;
      p[i] = diff < 0 ? u[i] - q[31:0] : u[i] + q[31:0];
    end
    return p;
  endfunction

  function automatic int sgn68(logic signed [67:0] x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  // Works out the segment, if any, that a triangle gives.
  function automatic bit slice_triangle(vec_t a, vec_t b, vec_t c, output seg_t seg);
    logic signed [67:0] da, db, dc;
    int sab, sbc, sca;
    vec_t p1, p2;
    bit pair;
    da = plane_gap(cut_plane, a);
    db = plane_gap(cut_plane, b);
    dc = plane_gap(cut_plane, c);
    sab = sgn68(da) * sgn68(db);
    sbc = sgn68(db) * sgn68(dc);
    sca = sgn68(dc) * sgn68(da);
    seg = '0;
    pair = 1'b1;
    if ((sab > 0 && sbc < 0 && sca < 0) || (sab < 0 && sbc > 0 && sca > 0)) begin
      p1 = edge_point(b, c, db, dc);
      p2 = edge_point(c, a, dc, da);
    end else if ((sab < 0 && sbc > 0 && sca < 0) || (sab > 0 && sbc < 0 && sca > 0)) begin
      p1 = edge_point(a, b, da, db);
      p2 = edge_point(c, a, dc, da);
    end else if ((sab < 0 && sbc < 0 && sca > 0) || (sab > 0 && sbc > 0 && sca < 0)) begin
      p1 = edge_point(a, b, da, db);
      p2 = edge_point(b, c, db, dc);
    end else begin
      pair = 1'b0;
    end
    if (pair) begin
      seg.st = p1;
      seg.fin = p2;
      return plane_gap(keep_plane, p1) >= -66 && plane_gap(keep_plane, p2) >= -66;
    end
    // A vertex close to the plane is paired with the crossing of its far edge.
    if ((da < 132 && da > -132) && sbc <= 0) begin
      if (db == 0 && dc == 0) return 0;
      p2 = edge_point(b, c, db, dc);
      p1 = a;
    end else if ((db < 132 && db > -132) && sca <= 0) begin
      if (dc == 0 && da == 0) return 0;
      p2 = edge_point(c, a, dc, da);
      p1 = b;
    end else if ((dc < 132 && dc > -132) && sab <= 0) begin
      if (da == 0 && db == 0) return 0;
      p2 = edge_point(a, b, da, db);
      p1 = c;
    end else begin
      return 0;
    end
    seg.st = p1;
    seg.fin = p2;
    return plane_gap(keep_plane, p2) > 0;
  endfunction

  task automatic note_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Writes both planes; only called while the core is idle.
  task automatic load_planes(plane_t cut, plane_t keep);
    logic [2:0] idx [8];
    logic [31:0] val [8];
    idx = '{REG_CUT_NX, REG_CUT_NY, REG_CUT_NZ, REG_CUT_OFF,
            REG_KEEP_NX, REG_KEEP_NY, REG_KEEP_NZ, REG_KEEP_OFF};
    val = '{cut.n[0], cut.n[1], cut.n[2], cut.off,
            keep.n[0], keep.n[1], keep.n[2], keep.off};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cut_plane = cut;
    keep_plane = keep;
    settings++;
  endtask

  // Stops sending, waits for every owed segment, then for anything in flight.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Offers one triangle and returns once it is accepted.
  task automatic send_triangle(vec_t a, vec_t b, vec_t c, bit pinned);
    int gap;
    seg_t seg;
    if (($urandom & 31) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    va <= a;
    vb <= b;
    vc <= c;
    do @(posedge clk); while (full);
    triangles++;
    if (!pinned && slice_triangle(a, b, c, seg))
      pending_segs.insert(pending_segs.size(), seg);
  endtask

  function automatic vec_t mk(int x, int y, int z);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  // A coordinate on the plane's axis: often a hair from the offset.
  function automatic logic [31:0] near_axis(logic [31:0] off);
    case ($urandom_range(0, 3))
      0: return off + $urandom_range(0, 400) - 200;
      1: return off + $urandom_range(0, 2 * ONE) - ONE;
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  function automatic vec_t rand_point(int kind);
    vec_t v;
    for (int i = 0; i < 3; i++) v[i] = $urandom_range(0, 1 << 19) - (1 << 18);
    if (kind == 0 || kind == 3) begin
      v[2] = near_axis(cut_plane.off);
      if ($urandom_range(0, 1)) v[0] = near_axis(keep_plane.off);
    end
    if (kind == 2 || $urandom_range(0, 9) == 0)
      for (int i = 0; i < 3; i++) v[i] = $urandom;
    return v;
  endfunction

  function automatic plane_t rand_plane(int kind, int axis);
    plane_t pl;
    pl = '0;
    case (kind)
      0: begin
        pl.n[axis] = UNIT;
        pl.off = $urandom_range(0, 1 << 17) - (1 << 16);
      end
      3: begin
        pl.n[axis] = -UNIT;
        pl.off = $urandom_range(0, 1 << 17) - (1 << 16);
      end
      1: begin
        for (int i = 0; i < 3; i++) pl.n[i] = $urandom_range(0, 32'h8000_0000) - UNIT;
        pl.off = $urandom_range(0, 1 << 17) - (1 << 16);
      end
      default: begin
        // Extremes of the normals and offsets, sometimes raw out-of-range words.
        for (int i = 0; i < 3; i++)
          pl.n[i] = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom_range(0, 1) ? UNIT : -UNIT);
        pl.off = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        if ($urandom_range(0, 2) == 0) pl.off = $urandom;
      end
    endcase
    return pl;
  endfunction

  // Result side: random stalls, each segment checked field by field.
  initial begin
    int gap;
    seg_t want;
    @(negedge rst);
    forever begin
      if (($urandom & 31) == 0) take_burst = ~take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      segments++;
      if (pending_segs.size() == 0) begin
        note_mismatch("segment word with no segment owed");
      end else begin
        want = pending_segs.pop_front();
        if (start_x !== want.st[0])
          note_mismatch($sformatf("start_x got %h, expected %h", start_x, want.st[0]));
        if (start_y !== want.st[1])
          note_mismatch($sformatf("start_y got %h, expected %h", start_y, want.st[1]));
        if (start_z !== want.st[2])
          note_mismatch($sformatf("start_z got %h, expected %h", start_z, want.st[2]));
        if (finish_x !== want.fin[0])
          note_mismatch($sformatf("finish_x got %h, expected %h", finish_x, want.fin[0]));
        if (finish_y !== want.fin[1])
          note_mismatch($sformatf("finish_y got %h, expected %h", finish_y, want.fin[1]));
        if (finish_z !== want.fin[2])
          note_mismatch($sformatf("finish_z got %h, expected %h", finish_z, want.fin[2]));
      end
    end
  end

  // Stimulus.
  initial begin
    tri_row_t rows[$];
    plane_t cut, keep;
    int kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the planes still at reset every distance is zero.
    for (int i = 0; i < 4; i++) send_triangle(rand_point(2), rand_point(2), rand_point(2), 0);
    wait_idle();

    // Cut at z = 0, keep everything with the largest negative offset.
    cut = '0;
    cut.n[2] = UNIT;
    keep = '0;
    keep.n[0] = UNIT;
    keep.off = 32'h8000_0000;
    load_planes(cut, keep);

    // Directed table: crossings in each edge pair, vertices near the plane,
    // the zero denominator, triangles that miss, extremes of the coordinates.
    rows = '{
      '{mk(0, 0, ONE), mk(ONE, 0, 2 * ONE), mk(0, ONE, -ONE), 0},
      '{mk(0, 0, -ONE), mk(ONE, 0, ONE), mk(0, ONE, -3 * ONE), 0},
      '{mk(0, 0, ONE), mk(ONE, 0, -ONE), mk(0, ONE, ONE), 0},
      '{mk(5, 7, 50), mk(ONE, 0, ONE), mk(0, ONE, -ONE), 0},
      '{mk(-ONE, 0, -ONE), mk(3, 3, -100), mk(0, ONE, ONE), 0},
      '{mk(ONE, ONE, ONE), mk(0, -ONE, -ONE), mk(9, 9, 0), 0},
      '{mk(0, 0, 131), mk(ONE, 0, ONE), mk(0, ONE, -ONE), 0},
      '{mk(0, 0, 132), mk(ONE, 0, ONE), mk(0, ONE, -ONE), 0},
      '{mk(0, 0, -131), mk(ONE, 0, -ONE), mk(0, ONE, ONE), 0},
      '{mk(0, 0, 10), mk(ONE, 0, 0), mk(0, ONE, 0), 1},
      '{mk(0, 0, ONE), mk(ONE, 0, 2), mk(0, ONE, 3 * ONE), 1},
      '{mk(0, 0, -ONE), mk(ONE, 0, -2 * ONE), mk(0, ONE, -500), 1},
      '{mk(0, 0, 0), mk(ONE, 0, 0), mk(0, ONE, 0), 1},
      '{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
        mk(32'h80000000, 32'h80000000, 32'h80000000), mk(0, 0, 0), 0},
      '{mk(32'h80000000, 32'h7fffffff, 32'h80000000),
        mk(32'h7fffffff, 32'h80000000, 32'h7fffffff), mk(1, -1, 1), 0},
      '{mk(-1, -1, 32'h7fffffff), mk(32'h7fffffff, 0, 32'h80000000),
        mk(32'h80000000, -1, 1), 0}
    };
    foreach (rows[i]) send_triangle(rows[i].a, rows[i].b, rows[i].c, rows[i].pinned);
    wait_idle();

    // Same rows with a keep plane that turns part of them away.
    keep.off = 0;
    load_planes(cut, keep);
    foreach (rows[i]) send_triangle(rows[i].a, rows[i].b, rows[i].c, rows[i].pinned);
    wait_idle();

    // Random part: one plane setting per phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      kind = ph % 4;
      load_planes(rand_plane(kind, 2), rand_plane(kind == 1 ? 1 : (kind == 2 ? 2 : 0), 0));
      for (int i = 0; i < PER_PHASE; i++) begin
        if (ph == 5 && i == PER_PHASE / 2) begin
          push <= 1'b0;
          while (pending_segs.size() != 0) @(posedge clk);
        end
        send_triangle(rand_point(kind), rand_point(kind), rand_point(kind), 0);
      end
      push <= 1'b0;
      wait_idle();
    end

    $display("%0d triangles under %0d plane settings, %0d segments returned",
             triangles, settings, segments);
    if (mismatches == 0) begin
      $display("** triangle_plane_slice_segment_core: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** triangle_plane_slice_segment_core: FAILED **");
    end
    $finish;
  end

endmodule
